// ----- rtl/core/wtsr_pkg.sv -----
// Shared types and constants for the wall texel span rasterizer.
package wtsr_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_GAME_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_GAME_WIDTH   = 2'd1;
  localparam logic [1:0] REG_PIXEL_SCALE  = 2'd2;
  localparam logic [1:0] REG_TEXTURE_ROWS = 2'd3;

  localparam int CFG_W = 11;

  localparam logic [10:0] MAX_GAME_DIM = 11'd1024;
  localparam logic [3:0]  MAX_SCALE    = 4'd8;

  // Span-end divider: 32-bit dividend, divisor 512*rows, 11-bit quotient with overflow flag
  localparam int NUM_W = 32;
  localparam int DIV_W = 18;
  localparam int QUO_W = 11;
  localparam int REM_W = DIV_W + QUO_W;

  // Edge of accept to edge at which the result strobe is sampled
  localparam int PIPE_LAT = QUO_W + 6;

  typedef struct packed {
    logic signed [10:0] column;
    logic [19:0]        wall_half_height;
    logic [7:0]         texel_step;
    logic [31:0]        texel_color;
  } in_word_t;

  typedef struct packed {
    logic [12:0] rect_left;
    logic [12:0] rect_right;
    logic [12:0] rect_top;
    logic [12:0] rect_bottom;
    logic [31:0] fill_color;
  } out_word_t;

  // Side data that rides along the divider
  typedef struct packed {
    logic [9:0]  col;
    logic        neg1;
    logic        neg2;
    logic [31:0] color;
  } tag_t;

endpackage

// ----- rtl/core/wall_texel_span_rasterizer_top.sv -----
// Top level of the wall texel span rasterizer: one texel step in, at most one clipped rectangle out.
//
//  channel   handshake          payload      width
//  input     start_i / busy_o   in_word_i    71
//  result    done_o (strobe)    out_word_o   84
//  config    cfg_we_i           cfg_idx_i, cfg_data_i  2 + 11
//
//  One word may enter every cycle; busy_o is never raised.
//  A result strobes done_o after its word passes stages A to D, the bit-per-stage
//  span divider and stages F and G; words that draw nothing give no strobe.
//  Reset clears the valid bits and loads the default register values.
//  The result side cannot stall, so the pipeline never holds.
module wall_texel_span_rasterizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  wtsr_pkg::in_word_t          in_word_i,
  output logic                        done_o,
  output wtsr_pkg::out_word_t         out_word_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [wtsr_pkg::CFG_W-1:0]  cfg_data_i
);

  // Configuration registers
  logic [10:0] game_height_q, game_width_q;
  logic [3:0]  pixel_scale_q;
  logic [8:0]  texture_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      game_height_q  <= 11'd200;
      game_width_q   <= 11'd320;
      pixel_scale_q  <= 4'd1;
      texture_rows_q <= 9'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wtsr_pkg::REG_GAME_HEIGHT:  game_height_q  <= cfg_data_i;
        wtsr_pkg::REG_GAME_WIDTH:   game_width_q   <= cfg_data_i;
        wtsr_pkg::REG_PIXEL_SCALE:  pixel_scale_q  <= cfg_data_i[3:0];
        wtsr_pkg::REG_TEXTURE_ROWS: texture_rows_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [10:0] gh_c, gw_c;
  logic [3:0]  s_c;
  logic [9:0]  half_c;

  assign gh_c   = (game_height_q > wtsr_pkg::MAX_GAME_DIM) ? wtsr_pkg::MAX_GAME_DIM
                                                           : game_height_q;
  assign gw_c   = (game_width_q > wtsr_pkg::MAX_GAME_DIM) ? wtsr_pkg::MAX_GAME_DIM
                                                          : game_width_q;
  assign s_c    = (pixel_scale_q > wtsr_pkg::MAX_SCALE) ? wtsr_pkg::MAX_SCALE : pixel_scale_q;
  assign half_c = gh_c[10:1];

  assign busy_o = 1'b0;

  // ---------------- stage A: checks, step multipliers ----------------
  logic               in_ok;
  logic               a_valid_q;
  logic [9:0]         a_col_q;
  logic [19:0]        a_w_q;
  logic signed [10:0] a_k1_q, a_k2_q;
  logic [31:0]        a_color_q;

  assign in_ok = (texture_rows_q != 9'd0) && ({1'b0, in_word_i.texel_step} < texture_rows_q) &&
                 (s_c != 4'd0) && (gh_c != 11'd0) && (gw_c != 11'd0) &&
                 !in_word_i.column[10] && ($unsigned(in_word_i.column) < gw_c);

  // ---------------- stage B: products ----------------
  logic               b_valid_q;
  logic [9:0]         b_col_q;
  logic [31:0]        b_color_q;
  logic signed [31:0] b_q1_q, b_q2_q, b_q1_d, b_q2_d;
  logic [18:0]        b_rh_q, b_rh_d;

  assign b_q1_d = $signed({1'b0, a_w_q}) * a_k1_q;
  assign b_q2_d = $signed({1'b0, a_w_q}) * a_k2_q;
  assign b_rh_d = 19'(texture_rows_q) * 19'(half_c);

  // ---------------- stage C: numerators ----------------
  logic               c_valid_q;
  logic [9:0]         c_col_q;
  logic [31:0]        c_color_q;
  logic signed [31:0] c_n1_q, c_n2_q;

  // ---------------- stage D: divider dividends ----------------
  logic               d_valid_q;
  logic [9:0]         d_col_q;
  logic [31:0]        d_color_q;
  logic               d_neg1_q, d_neg2_q;
  logic [31:0]        d_m1_q, d_m2_q;
  logic [33:0]        den34, n1x2, n2x2, m1_d, m2_d;

  assign den34 = {17'b0, texture_rows_q, 8'b0};
  assign n1x2  = {c_n1_q[31], c_n1_q, 1'b0};
  assign n2x2  = {c_n2_q[31], c_n2_q, 1'b0};
  // round: 2|n| + d over 2d; ceil: 2n + 2d - 2 over 2d, or 2|n| over 2d when negative
  assign m1_d  = c_n1_q[31] ? (den34 - n1x2) : (n1x2 + den34);
  assign m2_d  = c_n2_q[31] ? (34'd0 - n2x2) : (n2x2 + (den34 << 1) - 34'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && in_ok;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_col_q   <= in_word_i.column[9:0];
    a_w_q     <= in_word_i.wall_half_height;
    a_k1_q    <= $signed({2'b0, in_word_i.texel_step, 1'b0}) - $signed({2'b0, texture_rows_q});
    a_k2_q    <= $signed({2'b0, in_word_i.texel_step, 1'b0}) + 11'sd2
                 - $signed({2'b0, texture_rows_q});
    a_color_q <= in_word_i.texel_color;

    b_col_q   <= a_col_q;
    b_color_q <= a_color_q;
    b_q1_q    <= b_q1_d;
    b_q2_q    <= b_q2_d;
    b_rh_q    <= b_rh_d;

    c_col_q   <= b_col_q;
    c_color_q <= b_color_q;
    c_n1_q    <= $signed({5'b0, b_rh_q, 8'b0}) + b_q1_q;
    c_n2_q    <= $signed({5'b0, b_rh_q, 8'b0}) + b_q2_q;

    d_col_q   <= c_col_q;
    d_color_q <= c_color_q;
    d_neg1_q  <= c_n1_q[31];
    d_neg2_q  <= c_n2_q[31];
    d_m1_q    <= m1_d[31:0];
    d_m2_q    <= m2_d[31:0];
  end

  // ---------------- divider ----------------
  wtsr_pkg::tag_t                  div_tag_in, div_tag;
  logic                            div_vld;
  logic [1:0][wtsr_pkg::QUO_W-1:0] div_quo;
  logic [1:0]                      div_ovf;

  assign div_tag_in.col   = d_col_q;
  assign div_tag_in.neg1  = d_neg1_q;
  assign div_tag_in.neg2  = d_neg2_q;
  assign div_tag_in.color = d_color_q;

  wtsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid_q),
    .num_i   ({d_m2_q, d_m1_q}),
    .div_i   ({texture_rows_q, 9'b0}),
    .tag_i   (div_tag_in),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf),
    .tag_o   (div_tag)
  );

  // ---------------- stage F: order, clip ----------------
  logic signed [12:0] y1, y2, lo, hi, lo_c, hi_c, ghm1;
  logic               f_valid_q;
  logic [9:0]         f_lo_q, f_hi_q, f_col_q;
  logic [31:0]        f_color_q;

  // Negative ends give -1, or 0 for a zero quotient; saturated ends give 2047, off screen
  always_comb begin
    if (div_tag.neg1) begin
      y1 = (div_ovf[0] || (div_quo[0] != '0)) ? -13'sd1 : 13'sd0;
    end else begin
      y1 = div_ovf[0] ? 13'sd2047 : $signed({2'b0, div_quo[0]});
    end
    if (div_tag.neg2) begin
      y2 = (div_ovf[1] || (div_quo[1] != '0)) ? -13'sd1 : 13'sd0;
    end else begin
      y2 = div_ovf[1] ? 13'sd2047 : $signed({2'b0, div_quo[1]});
    end
    lo   = (y1 < y2) ? y1 : y2;
    hi   = (y1 < y2) ? y2 : y1;
    ghm1 = $signed({2'b0, gh_c}) - 13'sd1;
    lo_c = (lo < 13'sd0) ? 13'sd0 : lo;
    hi_c = (hi > ghm1) ? ghm1 : hi;
  end

  // ---------------- stage G: scale, flip ----------------
  logic [12:0] left_d, right_d, top_d;
  logic [13:0] bot_d;
  logic        done_q;
  wtsr_pkg::out_word_t out_q;

  assign left_d  = 13'({3'b0, f_col_q} * {9'b0, s_c});
  assign right_d = left_d + 13'(s_c) - 13'd1;
  assign top_d   = (13'(gh_c) - 13'd1 - 13'(f_hi_q)) * 13'(s_c);
  assign bot_d   = (14'(gh_c) - 14'(f_lo_q)) * 14'(s_c) - 14'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      f_valid_q <= div_vld && (lo_c <= hi_c);
      done_q    <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_lo_q    <= lo_c[9:0];
    f_hi_q    <= hi_c[9:0];
    f_col_q   <= div_tag.col;
    f_color_q <= div_tag.color;

    out_q.rect_left   <= left_d;
    out_q.rect_right  <= right_d;
    out_q.rect_top    <= top_d;
    out_q.rect_bottom <= bot_d[12:0];
    out_q.fill_color  <= f_color_q;
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, wtsr_pkg::PIPE_LAT))
    else $error("result without a word taken at the pipeline latency");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> $past(d_valid_q, wtsr_pkg::QUO_W))
    else $error("divider output out of step with its input");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid_q |-> (f_lo_q <= f_hi_q))
    else $error("clipped span reversed");
`endif

endmodule

// ----- rtl/core/wtsr_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage, with an overflow flag per lane.
module wtsr_div (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic [1:0][wtsr_pkg::NUM_W-1:0]          num_i,
  input  logic [wtsr_pkg::DIV_W-1:0]               div_i,
  input  wtsr_pkg::tag_t                           tag_i,
  output logic                                     valid_o,
  output logic [1:0][wtsr_pkg::QUO_W-1:0]          quo_o,
  output logic [1:0]                               ovf_o,
  output wtsr_pkg::tag_t                           tag_o
);

  logic [wtsr_pkg::QUO_W-1:0] vld_q;
  logic [wtsr_pkg::REM_W-1:0] rem_q [2][wtsr_pkg::QUO_W];
  logic [wtsr_pkg::REM_W-1:0] rem_d [2][wtsr_pkg::QUO_W];
  logic [wtsr_pkg::QUO_W-1:0] quo_q [2][wtsr_pkg::QUO_W];
  logic [wtsr_pkg::QUO_W-1:0] quo_d [2][wtsr_pkg::QUO_W];
  logic                       ovf_q [2][wtsr_pkg::QUO_W];
  logic                       ovf_d [2][wtsr_pkg::QUO_W];
  wtsr_pkg::tag_t             tag_q [wtsr_pkg::QUO_W];
  logic [wtsr_pkg::NUM_W-1:0] big;

  // Quotient would not fit in QUO_W bits
  assign big = wtsr_pkg::NUM_W'(div_i) << wtsr_pkg::QUO_W;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf_d[l][0] = num_i[l] >= big;
      quo_d[l][0] = '0;
      if (num_i[l][wtsr_pkg::REM_W-1:0] >=
          (wtsr_pkg::REM_W'(div_i) << (wtsr_pkg::QUO_W - 1))) begin
        rem_d[l][0] = num_i[l][wtsr_pkg::REM_W-1:0] -
                      (wtsr_pkg::REM_W'(div_i) << (wtsr_pkg::QUO_W - 1));
        quo_d[l][0][wtsr_pkg::QUO_W-1] = 1'b1;
      end else begin
        rem_d[l][0] = num_i[l][wtsr_pkg::REM_W-1:0];
      end
      for (int s = 1; s < wtsr_pkg::QUO_W; s++) begin
        ovf_d[l][s] = ovf_q[l][s-1];
        quo_d[l][s] = quo_q[l][s-1];
        if (rem_q[l][s-1] >= (wtsr_pkg::REM_W'(div_i) << (wtsr_pkg::QUO_W - 1 - s))) begin
          rem_d[l][s] = rem_q[l][s-1] -
                        (wtsr_pkg::REM_W'(div_i) << (wtsr_pkg::QUO_W - 1 - s));
          quo_d[l][s][wtsr_pkg::QUO_W-1-s] = 1'b1;
        end else begin
          rem_d[l][s] = rem_q[l][s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[wtsr_pkg::QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int s = 1; s < wtsr_pkg::QUO_W; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < wtsr_pkg::QUO_W; s++) begin
        rem_q[l][s] <= rem_d[l][s];
        quo_q[l][s] <= quo_d[l][s];
        ovf_q[l][s] <= ovf_d[l][s];
      end
    end
  end

  assign valid_o  = vld_q[wtsr_pkg::QUO_W-1];
  assign tag_o    = tag_q[wtsr_pkg::QUO_W-1];
  assign quo_o[0] = quo_q[0][wtsr_pkg::QUO_W-1];
  assign quo_o[1] = quo_q[1][wtsr_pkg::QUO_W-1];
  assign ovf_o[0] = ovf_q[0][wtsr_pkg::QUO_W-1];
  assign ovf_o[1] = ovf_q[1][wtsr_pkg::QUO_W-1];

endmodule
